[src/lkvc_pkg.sv]
// Package for the key/value cache with least-recently-used replacement.
// Holds the sizes, the request and response types and the capacity clamp.
// No dependencies.
package lkvc_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned RANK_W  = $clog2(ENTRIES);
  localparam int unsigned OCC_W   = $clog2(ENTRIES + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_SET = 1'b1
  } action_e;

  typedef struct packed {
    action_e                 action;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } rsp_t;

  // A capacity of zero behaves as one, and one above the store size as the store size.
  function automatic logic [OCC_W-1:0] clamp_cap(input logic [CAP_W-1:0] cap);
    logic [OCC_W-1:0] res;
    if (cap == '0) begin
      res = OCC_W'(1);
    end else if (32'(cap) > ENTRIES) begin
      res = OCC_W'(ENTRIES);
    end else begin
      res = OCC_W'(cap);
    end
    return res;
  endfunction

endpackage

[src/lkvc_store.sv]
// Entry store of the cache: keys, values, valid bits, recency ranks and occupancy,
// with the parallel key match and the recency rank update.
// Depends on lkvc_pkg.
module lkvc_store import lkvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  req_t             req_i,
  input  logic [OCC_W-1:0] cap_i,
  output rsp_t             rsp_o
);

  logic signed [KEY_W-1:0] key_q  [ENTRIES];
  logic signed [VAL_W-1:0] val_q  [ENTRIES];
  logic [RANK_W-1:0]       rank_q [ENTRIES];
  logic [RANK_W-1:0]       rank_d [ENTRIES];
  logic [ENTRIES-1:0]      valid_q, valid_d;
  logic [OCC_W-1:0]        occ_q, occ_d;

  logic [ENTRIES-1:0]      hit_vec, vict_vec, free_vec, tgt_vec;
  logic [RANK_W-1:0]       occ_last, sel_rank;
  logic signed [VAL_W-1:0] rd_val;
  logic                    hit_any, is_set, can_fill, do_fill, do_upd, wr_val, wr_key;

  always_comb begin
    occ_last = RANK_W'(occ_q - OCC_W'(1));
    free_vec = ~valid_q & (valid_q + ENTRIES'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]  = valid_q[i] && (key_q[i] == req_i.key);
      vict_vec[i] = valid_q[i] && (rank_q[i] == occ_last);
    end
    hit_any  = |hit_vec;
    is_set   = (req_i.action == ACT_SET);
    can_fill = (occ_q < cap_i);
    if (hit_any) begin
      tgt_vec = hit_vec;
    end else if (can_fill) begin
      tgt_vec = free_vec;
    end else begin
      tgt_vec = vict_vec;
    end

    sel_rank = '0;
    rd_val   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (tgt_vec[i]) begin
        sel_rank = sel_rank | rank_q[i];
      end
      if (hit_vec[i]) begin
        rd_val = rd_val | val_q[i];
      end
    end

    do_upd  = fire_i && (hit_any || is_set);
    do_fill = fire_i && is_set && !hit_any && can_fill;
    wr_val  = fire_i && is_set;
    wr_key  = fire_i && is_set && !hit_any;

    valid_d = valid_q;
    occ_d   = occ_q;
    if (do_fill) begin
      valid_d = valid_q | free_vec;
      occ_d   = occ_q + OCC_W'(1);
    end
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (do_upd) begin
        if (tgt_vec[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (do_fill || (rank_q[i] < sel_rank))) begin
          rank_d[i] = rank_q[i] + RANK_W'(1);
        end
      end
    end

    rsp_o.found      = hit_any;
    rsp_o.read_value = (hit_any && !is_set) ? rd_val : '0;
    rsp_o.evicted    = is_set && !hit_any && !can_fill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_val && tgt_vec[i]) begin
        val_q[i] <= req_i.value;
      end
      if (wr_key && tgt_vec[i]) begin
        key_q[i] <= req_i.key;
      end
    end
  end

endmodule

[src/lru_key_value_cache.sv]
// Top level of the key/value cache with least-recently-used replacement.
// Request register, entry store, response register and the capacity register.
// Depends on lkvc_pkg and lkvc_store.
//
//   channel   handshake                 payload
//   request   in_valid_i / in_stall_o   in_req_i   (req_t)
//   response  out_valid_o / out_stall_i out_rsp_o  (rsp_t)
//   config    cfg_valid_i / cfg_ready_o cfg_data_i (capacity)
//
// One request per cycle while the response side does not stall; a response is presented
// from the response register, once its request has left the request register.
// The lookup and the recency update of the whole store are done combinationally between
// the request register and the response register.
// Reset empties the cache and sets the capacity to sixteen; no clearing pass is needed.
// A stalled response holds the request register, which stalls the request side.
module lru_key_value_cache import lkvc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  logic             req_valid_q, req_valid_d;
  req_t             req_q;
  logic             out_valid_q, out_valid_d;
  rsp_t             rsp_q, rsp_c;
  logic [CAP_W-1:0] cap_q;
  logic             advance, fire, in_acc;

  always_comb begin
    advance     = !out_valid_q || !out_stall_i;
    fire        = req_valid_q && advance;
    in_stall_o  = req_valid_q && !advance;
    in_acc      = in_valid_i && !in_stall_o;
    req_valid_d = req_valid_q;
    if (in_acc) begin
      req_valid_d = 1'b1;
    end else if (fire) begin
      req_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  lkvc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .cap_i  (clamp_cap(cap_q)),
    .rsp_o  (rsp_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_c;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

[src/lkvc_checker.sv]
// Port-level checker for the key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker import lkvc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input req_t             in_req_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input rsp_t             out_rsp_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o,
  input logic [CAP_W-1:0] cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("Stalled response changed or was withdrawn.");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.found && out_rsp_o.evicted))
    else $error("A hit reported an eviction.");

  a_value_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.read_value != '0) |-> out_rsp_o.found)
    else $error("A value was returned without a hit.");

  a_resp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("A response appeared without a request two cycles earlier.");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);
